### rtl/fit_policy_hole_allocator_macros.svh
// Assertion macros for the hole allocator.
// Included by the top level; no other dependencies.
`ifndef FIT_POLICY_HOLE_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_HOLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fph_pkg.sv
// Shared constants, codes and types of the hole allocator.
// No dependencies; imported by fph_store and the top level.
`default_nettype none

package fph_pkg;

    localparam int HOLES     = 16;
    localparam int SIZE_BITS = 16;

    localparam int HOLE_AW = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W   = $clog2(HOLES + 1);
    localparam int ACC_W   = SIZE_BITS + CNT_W;
    localparam int AMT_W   = 16;
    localparam int IDX_W   = 4;
    localparam int CMP_W   = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
    localparam int SUM_W   = 20;
    localparam int MODE_W  = 2;
    localparam int HCNT_W  = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_HOLE_COUNT = 1'b1;

    typedef struct packed {
        logic                 wr_en;
        logic [HOLE_AW-1:0]   wr_addr;
        logic [SIZE_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [HOLE_AW-1:0]   rd_addr;
    } store_req_t;

endpackage

`default_nettype wire

### rtl/fph_store.sv
// Hole size store: synchronous memory with registered read data and per-entry valid bits.
// Depends on fph_pkg; an entry never written reads as zero.
`default_nettype none

module fph_store
    import fph_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire store_req_t           req,
    output logic [SIZE_BITS-1:0]      rd_data
);

    logic [SIZE_BITS-1:0] mem [HOLES];
    logic [HOLES-1:0]     valid_reg;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // mask entries that were never loaded since reset
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### rtl/fit_policy_hole_allocator.sv
// Hole allocator: first/best/worst fit placement over a table of hole sizes.
// Items are taken one at a time: input is ready only in idle, so a new beat waits until the
// last one has finished. Steps: accept, one read per entry, a step that folds the last read,
// one more before finish, then write-back (finish waits while the output beat is held).
// Reset: fit first, 16 holes, no failure, all holes read as zero (store valid bits clear).
`default_nettype none

module fit_policy_hole_allocator
    import fph_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_wdata,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // [3:0] hole_index, [19:4] amount, zero fill
    input  wire logic         s_axis_tuser,   // [0] func
    input  wire logic         s_axis_tlast,   // last_request
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [3:0] chosen_hole, [23:4] fragmentation,
                                              // [43:24] free_total, zero fill
    output logic [1:0]        m_axis_tuser,   // [0] granted, [1] run_failed
    output logic              m_axis_tlast    // run_done
);

`include "fit_policy_hole_allocator_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [MODE_W-1:0] fit_mode_reg;
    logic [HCNT_W-1:0] hole_count_reg;

    // latched item
    logic              func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  n_reg;

    // scan state
    logic [CNT_W-1:0]   issue_reg;
    logic               rd_v_reg;
    logic [HOLE_AW-1:0] rd_idx_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               found_reg;
    logic [HOLE_AW-1:0] best_reg;
    logic [CMP_W-1:0]   best_left_reg;

    logic failed_reg;

    // output register
    logic              out_valid_reg;
    logic              out_granted_reg;
    logic [IDX_W-1:0]  out_chosen_reg;
    logic              out_failed_reg;
    logic              out_done_reg;
    logic [SUM_W-1:0]  out_frag_reg;
    logic [SUM_W-1:0]  out_free_reg;

    store_req_t           store_req;
    logic [SIZE_BITS-1:0] rd_data;

    fph_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // -------------------------------------------------------------------
    // Input accept and holes in use (counts above HOLES act as HOLES)
    // -------------------------------------------------------------------
    logic             in_beat;
    logic [CNT_W-1:0] n_in_use;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign n_in_use      = (32'(hole_count_reg) > HOLES) ? CNT_W'(HOLES)
                                                          : CNT_W'(hole_count_reg);

    // -------------------------------------------------------------------
    // Scan: one read issued per cycle, the returning entry folded in next
    // -------------------------------------------------------------------
    logic                 issue;
    logic [SIZE_BITS-1:0] entry;
    logic [CMP_W-1:0]     entry_c;
    logic [CMP_W-1:0]     req_c;
    logic [CMP_W-1:0]     left;
    logic                 fits;
    logic                 take;

    assign issue = (state_reg == ST_SCAN) && (issue_reg < n_reg);

    // a load sees its own new size so the free sum already includes it
    assign entry   = (func_reg == FUNC_LOAD && 32'(idx_reg) == 32'(rd_idx_reg))
                   ? SIZE_BITS'(amt_reg) : rd_data;
    assign entry_c = CMP_W'(entry);
    assign req_c   = CMP_W'(amt_reg);
    assign fits    = entry_c >= req_c;
    assign left    = entry_c - req_c;

    // ties keep the earlier index; first fit stops updating after the first hit
    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (fit_mode_reg)
                    FIT_BEST:  take = left < best_left_reg;
                    FIT_WORST: take = left > best_left_reg;
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    // -------------------------------------------------------------------
    // Finish: resolve the item, write back, build the result beat
    // -------------------------------------------------------------------
    logic             can_finish;
    logic             is_load;
    logic             grant;
    logic             failed_new;
    logic             done_new;
    logic [ACC_W-1:0] sum_raw;
    logic [SUM_W-1:0] sum_sat;

    assign can_finish = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);
    assign is_load    = (func_reg == FUNC_LOAD);
    assign grant      = !is_load && !failed_reg && found_reg;
    assign failed_new = !is_load && (failed_reg || !found_reg);
    assign sum_raw    = grant ? (acc_reg - ACC_W'(amt_reg)) : acc_reg;
    assign sum_sat    = (64'(sum_raw) > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_raw);

    always_comb
    begin
        if (is_load)
        begin
            done_new = 1'b0;
        end
        else if (failed_reg || found_reg)
        begin
            done_new = last_reg;
        end
        else
        begin
            done_new = 1'b1;
        end
    end

    always_comb
    begin
        store_req.rd_en   = issue;
        store_req.rd_addr = HOLE_AW'(issue_reg);
        store_req.wr_en   = can_finish && (is_load ? (32'(idx_reg) < HOLES) : grant);
        store_req.wr_addr = is_load ? HOLE_AW'(idx_reg) : best_reg;
        store_req.wr_data = is_load ? SIZE_BITS'(amt_reg) : SIZE_BITS'(best_left_reg);
    end

    // -------------------------------------------------------------------
    // State and registered outputs
    // -------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_mode_reg   <= FIT_FIRST;
            hole_count_reg <= HCNT_W'(16);
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_v_reg       <= 1'b0;
            issue_reg      <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIT_MODE:   fit_mode_reg   <= cfg_wdata[MODE_W-1:0];
                    CFG_HOLE_COUNT: hole_count_reg <= cfg_wdata;
                    default:        ;
                endcase
            end

            // drop the beat once taken, unless a new one replaces it now
            if (out_valid_reg && m_axis_tready && !can_finish)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        func_reg  <= s_axis_tuser;
                        idx_reg   <= s_axis_tdata[IDX_W-1:0];
                        amt_reg   <= s_axis_tdata[IDX_W +: AMT_W];
                        last_reg  <= s_axis_tlast;
                        n_reg     <= n_in_use;
                        issue_reg <= '0;
                        rd_v_reg  <= 1'b0;
                        acc_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_v_reg   <= issue;
                    rd_idx_reg <= HOLE_AW'(issue_reg);
                    if (issue)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (rd_v_reg)
                    begin
                        acc_reg <= acc_reg + ACC_W'(entry);
                        if (take)
                        begin
                            found_reg     <= 1'b1;
                            best_reg      <= rd_idx_reg;
                            best_left_reg <= left;
                        end
                    end
                    // advance once every read has been issued and folded in
                    if (!issue && !rd_v_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (can_finish)
                    begin
                        failed_reg      <= failed_new;
                        out_valid_reg   <= 1'b1;
                        out_granted_reg <= grant;
                        out_chosen_reg  <= grant ? IDX_W'(best_reg) : '0;
                        out_failed_reg  <= failed_new;
                        out_done_reg    <= done_new;
                        out_frag_reg    <= failed_new ? sum_sat : '0;
                        out_free_reg    <= sum_sat;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_free_reg, out_frag_reg, out_chosen_reg};
    assign m_axis_tuser  = {out_failed_reg, out_granted_reg};
    assign m_axis_tlast  = out_done_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    `FPH_ASSERT_IMP(a_grant_not_failed, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        !m_axis_tuser[1], "granted beat reports a failed run")
    `FPH_ASSERT_IMP(a_frag_only_failed, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1],
        m_axis_tdata[23:4] == '0, "fragmentation without a failed run")
    `FPH_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_beat,
        !s_axis_tready, "input accepted again before the item finished")
    `FPH_ASSERT_IMP(a_write_in_finish, clk, rst_n, store_req.wr_en,
        state_reg == ST_FINISH && !store_req.rd_en, "store written outside finish")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for fit_policy_hole_allocator: directed table, then random runs.
// Checks every result beat against a cycle-free allocator model here or a hand-typed want.
// Depends on rtl/fph_pkg.sv and the RTL of the block.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fph_pkg::*;

    // Policy code 3 is unused by the block and behaves as first fit.
    localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

    // Settle at the end for a span derived from the slowest beat.
    localparam int BEAT_CYCLES    = HOLES + 4;
    localparam int SETTLE_CYCLES  = 2 * BEAT_CYCLES;
    // Cycles without any handshake on either side before giving up.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BLOCK_BEATS    = 156;

    // One input beat, fields in the order of the request.
    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  hole_index;
        logic [AMT_W-1:0]  amount;
        logic              last_req;
    } alloc_item_t;

    // One result beat.
    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  chosen_hole;
        logic              run_failed;
        logic              run_done;
        logic [SUM_W-1:0]  fragmentation;
        logic [SUM_W-1:0]  free_total;
    } alloc_result_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // One row of the directed table: either a beat or a policy change.
    typedef struct {
        row_kind_t          kind;
        alloc_item_t        item;
        logic [MODE_W-1:0]  mode;
        logic [HCNT_W-1:0]  count;
        bit                 typed;
        alloc_result_t      want;
    } stim_row_t;

    // Random block settings: policy and hole count walk through the extremes,
    // including "no hole in use" and counts beyond the table.
    localparam logic [MODE_W-1:0] BLOCK_MODES [8] = '{
        FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE, FIT_BEST, FIT_WORST, FIT_FIRST, FIT_BEST
    };
    localparam logic [HCNT_W-1:0] BLOCK_COUNTS [8] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd16
    };
    // Idling phases: none, sender idle, receiver stalling, both.
    localparam int SEND_IDLE [4] = '{0, 59, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 59, 26};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_FIT_MODE;
    logic [4:0]         cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;  // [3:0] hole_index, [19:4] amount, zero fill
    logic               s_axis_tuser = 1'b0; // [0] func
    logic               s_axis_tlast = 1'b0; // last_request
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;       // [3:0] chosen_hole, [23:4] fragmentation,
                                            // [43:24] free_total, zero fill
    logic [1:0]         m_axis_tuser;       // [0] granted, [1] run_failed
    logic               m_axis_tlast;       // run_done

    // Allocator model state: mirrors the block after every accepted beat.
    logic [SIZE_BITS-1:0] hole_pool [HOLES] = '{default: '0};
    logic [MODE_W-1:0]    fit_policy = FIT_FIRST;
    logic [HCNT_W-1:0]    holes_cfg = 5'd16;
    logic                 alloc_failed = 1'b0;

    alloc_result_t pending_outcomes [$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;

    fit_policy_hole_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Advance the allocator model by one beat and return the result it owes.
    function automatic alloc_result_t predict_allocation(input alloc_item_t it);
        alloc_result_t         r;
        int                    n;
        int                    i;
        bit                    found;
        int                    pick;
        logic [SIZE_BITS-1:0]  left;
        logic [SIZE_BITS-1:0]  best_left;
        logic [23:0]           acc;
        r = '0;
        n = (holes_cfg > HOLES) ? HOLES : int'(holes_cfg);
        if (it.func == FUNC_LOAD) begin
            // A load always clears the sticky failure.
            hole_pool[it.hole_index] = it.amount;
            alloc_failed = 1'b0;
        end else if (alloc_failed) begin
            // Refused: nothing placed, only the run end is passed through.
            r.run_done = it.last_req;
        end else begin
            found = 1'b0;
            pick = 0;
            best_left = '0;
            for (i = 0; i < n; i++) begin
                if (hole_pool[i] >= it.amount) begin
                    left = hole_pool[i] - it.amount;
                    if (!found) begin
                        found = 1'b1;
                        pick = i;
                        best_left = left;
                        // First fit (and the spare code) stops at the first hole.
                        if (fit_policy != FIT_BEST && fit_policy != FIT_WORST)
                            break;
                    end else if (fit_policy == FIT_BEST && left < best_left) begin
                        pick = i;
                        best_left = left;
                    end else if (fit_policy == FIT_WORST && left > best_left) begin
                        pick = i;
                        best_left = left;
                    end
                end
            end
            if (found) begin
                hole_pool[pick] = hole_pool[pick] - it.amount;
                r.granted = 1'b1;
                r.chosen_hole = pick[IDX_W-1:0];
                r.run_done = it.last_req;
            end else begin
                alloc_failed = 1'b1;
                r.run_done = 1'b1;
            end
        end
        // Sum only the entries in use, saturating at the field width.
        acc = '0;
        for (i = 0; i < n; i++)
            acc = acc + {8'b0, hole_pool[i]};
        if (acc > {4'b0, SUM_MAX})
            acc = {4'b0, SUM_MAX};
        r.run_failed = alloc_failed;
        r.free_total = acc[SUM_W-1:0];
        r.fragmentation = alloc_failed ? acc[SUM_W-1:0] : '0;
        return r;
    endfunction

    function automatic stim_row_t beat_row(input logic func, input int idx, input int amt,
                                           input logic last);
        stim_row_t r;
        r.kind = ROW_BEAT;
        r.item.func = func;
        r.item.hole_index = IDX_W'(idx);
        r.item.amount = AMT_W'(amt);
        r.item.last_req = last;
        r.mode = '0;
        r.count = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // A beat whose result is obvious enough to type in by hand.
    function automatic stim_row_t known_row(input logic func, input int idx, input int amt,
                                            input logic last, input logic g, input int hole,
                                            input logic f, input logic d, input int frag,
                                            input int free);
        stim_row_t r;
        r = beat_row(func, idx, amt, last);
        r.typed = 1'b1;
        r.want.granted = g;
        r.want.chosen_hole = IDX_W'(hole);
        r.want.run_failed = f;
        r.want.run_done = d;
        r.want.fragmentation = SUM_W'(frag);
        r.want.free_total = SUM_W'(free);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [MODE_W-1:0] mode, input int count);
        stim_row_t r;
        r = beat_row(FUNC_LOAD, 0, 0, 1'b0);
        r.kind = ROW_CFG;
        r.mode = mode;
        r.count = HCNT_W'(count);
        return r;
    endfunction

    // Hole sizes and request sizes: mostly moderate, with zero, full scale and random bits.
    function automatic logic [AMT_W-1:0] pick_amount(input bit for_request);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return AMT_W'($urandom);
            2: return '1;
            default: return for_request ? AMT_W'($urandom_range(0, 1500))
                                        : AMT_W'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                 what, results_seen, want, got);
    endtask

    // Offer one beat, idling first at the phase's rate, and hold it until accepted.
    // Acceptance is judged from pre-edge values, so the model steps at that edge.
    task automatic send_beat(input alloc_item_t it, input bit typed = 1'b0,
                             input alloc_result_t want = '0);
        alloc_result_t model_out;
        alloc_result_t owed;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, it.amount, it.hole_index};
        s_axis_tuser <= it.func;
        s_axis_tlast <= it.last_req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        model_out = predict_allocation(it);
        owed = typed ? want : model_out;
        pending_outcomes = {pending_outcomes, owed};
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers on consecutive edges; the model keeps only the used bits.
    task automatic write_policy(input logic [4:0] mode_word, input logic [4:0] count_word);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FIT_MODE;
        cfg_wdata <= mode_word;
        @(posedge clk);
        cfg_index <= CFG_HOLE_COUNT;
        cfg_wdata <= count_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        fit_policy = mode_word[MODE_W-1:0];
        holes_cfg = count_word;
    endtask

    // Receiver backpressure at the phase's stall rate.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Compare every accepted result beat with the oldest owed result.
    always @(posedge clk) begin : result_check
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.granted = m_axis_tuser[0];
            got.run_failed = m_axis_tuser[1];
            got.run_done = m_axis_tlast;
            got.chosen_hole = m_axis_tdata[3:0];
            got.fragmentation = m_axis_tdata[23:4];
            got.free_total = m_axis_tdata[43:24];
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unowed result", 0, longint'(got));
            end else begin
                want = pending_outcomes.pop_front();
                if (got.granted !== want.granted)
                    report_mismatch("granted", want.granted, got.granted);
                if (got.chosen_hole !== want.chosen_hole)
                    report_mismatch("chosen_hole", want.chosen_hole, got.chosen_hole);
                if (got.run_failed !== want.run_failed)
                    report_mismatch("run_failed", want.run_failed, got.run_failed);
                if (got.run_done !== want.run_done)
                    report_mismatch("run_done", want.run_done, got.run_done);
                if (got.fragmentation !== want.fragmentation)
                    report_mismatch("fragmentation", want.fragmentation, got.fragmentation);
                if (got.free_total !== want.free_total)
                    report_mismatch("free_total", want.free_total, got.free_total);
            end
            results_seen++;
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   rows [$];
        alloc_item_t it;
        int          blk;
        int          sent;
        int          loads;
        int          asks;
        int          j;

        // Directed table. After reset every hole is zero, so a zero request fits
        // hole 0, any larger one fails and sets the sticky flag, and the next
        // request is refused until a load clears it.
        rows = {rows, known_row(FUNC_REQ, 0, 0, 1'b1, 1'b1, 0, 1'b0, 1'b1, 0, 0)};
        rows = {rows, known_row(FUNC_REQ, 0, 1, 1'b0, 1'b0, 0, 1'b1, 1'b1, 0, 0)};
        rows = {rows, known_row(FUNC_REQ, 15, 'hFFFF, 1'b0, 1'b0, 0, 1'b1, 1'b0, 0, 0)};
        // A load ignores last_request and clears the failure.
        rows = {rows, known_row(FUNC_LOAD, 15, 'hFFFF, 1'b1, 1'b0, 0, 1'b0, 1'b0, 0,
                                'hFFFF)};
        rows = {rows, beat_row(FUNC_LOAD, 0, 100, 1'b0)};
        rows = {rows, beat_row(FUNC_LOAD, 3, 40, 1'b0)};
        rows = {rows, beat_row(FUNC_LOAD, 7, 300, 1'b0)};
        rows = {rows, beat_row(FUNC_REQ, 9, 40, 1'b0)};
        // Full-scale request: exact fit in the top hole.
        rows = {rows, beat_row(FUNC_REQ, 0, 'hFFFF, 1'b1)};
        // Best fit prefers exact fits.
        rows = {rows, cfg_row(FIT_BEST, 16)};
        rows = {rows, beat_row(FUNC_REQ, 0, 40, 1'b0)};
        rows = {rows, beat_row(FUNC_REQ, 0, 60, 1'b1)};
        // Worst fit, then a zero request that fits everywhere.
        rows = {rows, cfg_row(FIT_WORST, 16)};
        rows = {rows, beat_row(FUNC_LOAD, 5, 500, 1'b0)};
        rows = {rows, beat_row(FUNC_REQ, 0, 100, 1'b0)};
        rows = {rows, beat_row(FUNC_REQ, 0, 0, 1'b1)};
        // No hole in use: every request fails with nothing free.
        rows = {rows, cfg_row(FIT_SPARE, 0)};
        rows = {rows, known_row(FUNC_REQ, 0, 0, 1'b0, 1'b0, 0, 1'b1, 1'b1, 0, 0)};
        rows = {rows, known_row(FUNC_REQ, 0, 5, 1'b1, 1'b0, 0, 1'b1, 1'b1, 0, 0)};
        rows = {rows, known_row(FUNC_LOAD, 2, 7, 1'b0, 1'b0, 0, 1'b0, 1'b0, 0, 0)};
        // Count past the table acts as the full table; the spare code is first fit.
        rows = {rows, cfg_row(FIT_SPARE, 31)};
        rows = {rows, beat_row(FUNC_REQ, 0, 1, 1'b0)};
        // Single hole in use.
        rows = {rows, cfg_row(FIT_WORST, 1)};
        rows = {rows, beat_row(FUNC_REQ, 0, 'hFFFF, 1'b1)};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                drain_results();
                write_policy({3'b000, rows[r].mode}, rows[r].count);
            end else begin
                send_beat(rows[r].item, rows[r].typed, rows[r].want);
            end
        end

        // Random blocks. Most traffic is well-formed runs: reload some holes,
        // then a burst of requests closed by last_request. The rest is noise.
        for (blk = 0; blk < 8; blk++) begin
            // Policy changes only with the pipe empty.
            drain_results();
            send_idle_pct = SEND_IDLE[blk % 4];
            recv_stall_pct = RECV_STALL[blk % 4];
            // Upper bits of the mode word are don't-care; exercise them.
            write_policy({3'($urandom_range(0, 7)), BLOCK_MODES[blk]}, BLOCK_COUNTS[blk]);
            sent = 0;
            while (sent < BLOCK_BEATS) begin
                if ($urandom_range(0, 99) < 15) begin
                    it.func = 1'($urandom);
                    it.hole_index = IDX_W'($urandom);
                    it.amount = AMT_W'($urandom);
                    it.last_req = 1'($urandom);
                    send_beat(it);
                    sent++;
                end else begin
                    loads = $urandom_range(1, 6);
                    asks = $urandom_range(1, 10);
                    for (j = 0; j < loads; j++) begin
                        it.func = FUNC_LOAD;
                        it.hole_index = IDX_W'($urandom_range(0, HOLES - 1));
                        it.amount = pick_amount(1'b0);
                        it.last_req = 1'($urandom);
                        send_beat(it);
                    end
                    for (j = 0; j < asks; j++) begin
                        it.func = FUNC_REQ;
                        it.hole_index = IDX_W'($urandom);
                        it.amount = pick_amount(1'b1);
                        it.last_req = (j == asks - 1);
                        send_beat(it);
                    end
                    sent += loads + asks;
                end
            end
        end

        // Wait out every owed result, then let the block settle.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/fph_pkg.sv
rtl/fph_store.sv
rtl/fit_policy_hole_allocator.sv
sim/tb_top.sv
